### hw/rtl/amfp_pkg.sv
// Shared types and constants for the ASCII motion frame parser.
// No dependencies; imported by every amfp module and the top level.
`timescale 1ns / 1ps

package amfp_pkg;

  localparam logic [7:0] ChDollar = 8'h24;  // '$'
  localparam logic [7:0] ChM      = 8'h4D;  // 'M'
  localparam logic [7:0] ChComma  = 8'h2C;  // ','
  localparam logic [7:0] ChHash   = 8'h23;  // '#'
  localparam logic [7:0] ChMinus  = 8'h2D;  // '-'
  localparam logic [7:0] ChPlus   = 8'h2B;  // '+'
  localparam logic [7:0] ChZero   = 8'h30;  // '0'
  localparam logic [7:0] ChNine   = 8'h39;  // '9'

  localparam int unsigned MaskW   = 9;
  localparam logic [MaskW-1:0] MaskReset = 9'd153;
  localparam logic [3:0]  PointMax = 4'd9;
  localparam logic [1:0]  ModeTwo   = 2'd2;
  localparam logic [1:0]  ModeThree = 2'd3;
  localparam logic [1:0]  ModeNone  = 2'd0;

  typedef enum logic [3:0] {
    PH_HUNT     = 4'd0,
    PH_DOLLAR   = 4'd1,
    PH_DOLLAR_M = 4'd2,
    PH_F0_START = 4'd3,
    PH_F0_SIGN  = 4'd4,
    PH_F0_DIG   = 4'd5,
    PH_F1_START = 4'd6,
    PH_F1_SIGN  = 4'd7,
    PH_F1_DIG   = 4'd8,
    PH_F2_START = 4'd9,
    PH_F2_SIGN  = 4'd10,
    PH_F2_DIG   = 4'd11,
    PH_IDLE     = 4'd12
  } phase_e;

  typedef enum logic [1:0] {
    SUB_START = 2'd0,
    SUB_SIGN  = 2'd1,
    SUB_DIG   = 2'd2
  } sub_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       packet_end;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] rate_tenths;
    logic signed [31:0] delta_tenths;
    logic               point_changed;
    logic [3:0]         current_point;
    logic [1:0]         drive_mode;
  } result_t;

endpackage

### hw/rtl/amfp_in_stage.sv
// Input register for received bytes; holds one request until the parser takes it.
// Depends on amfp_pkg.
`timescale 1ns / 1ps

module amfp_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  amfp_pkg::in_req_t in_req_i,
  input  logic             advance_i,
  output logic             valid_o,
  output amfp_pkg::in_req_t req_o
);
  import amfp_pkg::*;

  logic    valid_q, valid_d;
  in_req_t req_q;
  logic    accept;

  // Stall only when holding a request that is not moving on this cycle.
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

### hw/rtl/amfp_parser.sv
// Frame parse state machine: header hunt, three signed decimal fields, point update.
// Depends on amfp_pkg. Emits a combinational result for the output register.
`timescale 1ns / 1ps

module amfp_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  amfp_pkg::in_req_t        req_i,
  input  logic [amfp_pkg::MaskW-1:0] mask_i,
  output logic                     res_valid_o,
  output amfp_pkg::result_t        res_o
);
  import amfp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [30:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic [31:0] first_q, first_d;
  logic [31:0] second_q, second_d;
  logic [3:0]  point_q, point_d;

  logic        is_field;
  logic [1:0]  field;
  sub_e        sub;
  logic [7:0]  c;
  logic        digit;
  logic        sign_ch;
  logic [3:0]  digit_val;
  logic [34:0] acc_x10;
  logic [30:0] acc_next;
  logic [31:0] sval;
  logic        emit;
  logic        point_new;
  logic [15:0] mask_ext;
  logic [3:0]  mask_idx;

  function automatic phase_e start_phase(input logic [1:0] f);
    phase_e p;
    case (f)
      2'd0:    p = PH_F0_START;
      2'd1:    p = PH_F1_START;
      default: p = PH_F2_START;
    endcase
    return p;
  endfunction

  function automatic phase_e sign_phase(input logic [1:0] f);
    phase_e p;
    case (f)
      2'd0:    p = PH_F0_SIGN;
      2'd1:    p = PH_F1_SIGN;
      default: p = PH_F2_SIGN;
    endcase
    return p;
  endfunction

  function automatic phase_e dig_phase(input logic [1:0] f);
    phase_e p;
    case (f)
      2'd0:    p = PH_F0_DIG;
      2'd1:    p = PH_F1_DIG;
      default: p = PH_F2_DIG;
    endcase
    return p;
  endfunction

  assign c         = req_i.rx_byte;
  assign digit     = (c >= ChZero) && (c <= ChNine);
  assign sign_ch   = (c == ChMinus) || (c == ChPlus);
  assign digit_val = 4'(c - ChZero);

  // acc*10 + digit, saturated to 2^31-1
  assign acc_x10  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {31'b0, digit_val};
  assign acc_next = (acc_x10[34:31] != 4'b0) ? {31{1'b1}} : acc_x10[30:0];
  assign sval     = neg_q ? (32'd0 - {1'b0, acc_q}) : {1'b0, acc_q};

  // Decode field number and position within the field.
  always_comb begin
    is_field = 1'b1;
    field    = 2'd0;
    sub      = SUB_START;
    unique case (phase_q)
      PH_F0_START: begin field = 2'd0; sub = SUB_START; end
      PH_F0_SIGN:  begin field = 2'd0; sub = SUB_SIGN;  end
      PH_F0_DIG:   begin field = 2'd0; sub = SUB_DIG;   end
      PH_F1_START: begin field = 2'd1; sub = SUB_START; end
      PH_F1_SIGN:  begin field = 2'd1; sub = SUB_SIGN;  end
      PH_F1_DIG:   begin field = 2'd1; sub = SUB_DIG;   end
      PH_F2_START: begin field = 2'd2; sub = SUB_START; end
      PH_F2_SIGN:  begin field = 2'd2; sub = SUB_SIGN;  end
      PH_F2_DIG:   begin field = 2'd2; sub = SUB_DIG;   end
      default:     is_field = 1'b0;
    endcase
  end

  assign emit = is_field && !digit && (sub == SUB_DIG) && (field == 2'd2) && (c == ChHash);
  assign point_new = !neg_q && (acc_q != 31'd0) && (acc_q <= {27'b0, PointMax})
                     && (acc_q[3:0] != point_q);

  // Next state
  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    first_d  = first_q;
    second_d = second_q;
    point_d  = point_q;
    unique case (phase_q)
      PH_HUNT: begin
        if (c == ChDollar) phase_d = PH_DOLLAR;
      end
      PH_DOLLAR: begin
        if (c == ChM) phase_d = PH_DOLLAR_M;
        else if (c != ChDollar) phase_d = PH_HUNT;
      end
      PH_DOLLAR_M: begin
        if (c == ChComma) begin
          phase_d = PH_F0_START;
          acc_d   = '0;
          neg_d   = 1'b0;
        end else if (c == ChDollar) begin
          phase_d = PH_DOLLAR;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      default: begin
        if (!is_field) begin
          phase_d = PH_IDLE;
        end else if (digit) begin
          acc_d   = acc_next;
          phase_d = dig_phase(field);
        end else if (sub == SUB_START && sign_ch) begin
          neg_d   = (c == ChMinus);
          phase_d = sign_phase(field);
        end else if (sub != SUB_DIG) begin
          phase_d = PH_IDLE;
        end else if (field != 2'd2) begin
          if (c != ChComma) begin
            phase_d = PH_IDLE;
          end else begin
            if (field == 2'd0) first_d = sval;
            else second_d = sval;
            acc_d   = '0;
            neg_d   = 1'b0;
            phase_d = start_phase(field + 2'd1);
          end
        end else begin
          phase_d = PH_IDLE;
          if (emit && point_new) point_d = acc_q[3:0];
        end
      end
    endcase
    // End of packet always returns to the header hunt.
    if (req_i.packet_end) begin
      phase_d = PH_HUNT;
      acc_d   = '0;
      neg_d   = 1'b0;
    end
  end

  // Result fields
  assign mask_ext = {{(16 - MaskW){1'b0}}, mask_i};
  assign mask_idx = acc_q[3:0] - 4'd1;

  always_comb begin
    res_valid_o         = step_i && emit;
    res_o.rate_tenths   = first_q;
    res_o.delta_tenths  = second_q;
    res_o.point_changed = point_new;
    res_o.current_point = point_d;
    res_o.drive_mode    = ModeNone;
    if (point_new) begin
      res_o.drive_mode = mask_ext[mask_idx] ? ModeTwo : ModeThree;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      acc_q    <= '0;
      neg_q    <= 1'b0;
      first_q  <= '0;
      second_q <= '0;
      point_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      neg_q    <= neg_d;
      first_q  <= first_d;
      second_q <= second_d;
      point_q  <= point_d;
    end
  end

endmodule

### hw/rtl/amfp_out_stage.sv
// Result register; holds a finished frame result until the sink takes it.
// Depends on amfp_pkg.
`timescale 1ns / 1ps

module amfp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  amfp_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output amfp_pkg::result_t res_o
);
  import amfp_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### hw/rtl/ascii_motion_frame_parser.sv
// Top level of the ASCII motion frame parser: input register, parser, result register.
// Depends on amfp_pkg, amfp_in_stage, amfp_parser, amfp_out_stage.
//
//   channel | signals                                     | dir
//   --------+---------------------------------------------+-----
//   in      | in_valid_i, in_stall_o, rx_byte_i,          | in
//           | packet_end_i                                |
//   out     | out_valid_o, out_stall_i, rate_tenths_o,    | out
//           | delta_tenths_o, point_changed_o,            |
//           | current_point_o, drive_mode_o               |
//   cfg     | cfg_we_i, cfg_data_i (mode_two_point_mask)  | in
//
// One byte per cycle while the output is not stalled: a request waits in the input register, is parsed
// in a single pass, and a closing '#' lands in the result register the next edge.
// Reset clears the parse phase, values and stored point; the mask returns to 153.
// Output stall holds the result register and, through it, the input register.
`timescale 1ns / 1ps

module ascii_motion_frame_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               packet_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] rate_tenths_o,
  output logic signed [31:0] delta_tenths_o,
  output logic               point_changed_o,
  output logic [3:0]         current_point_o,
  output logic [1:0]         drive_mode_o,
  input  logic               cfg_we_i,
  input  logic [8:0]         cfg_data_i
);
  import amfp_pkg::*;

  logic [MaskW-1:0] mask_q;
  in_req_t in_req;
  in_req_t stg_req;
  logic    stg_valid;
  logic    out_free;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MaskReset;
    end else if (cfg_we_i) begin
      mask_q <= cfg_data_i;
    end
  end

  assign in_req.rx_byte    = rx_byte_i;
  assign in_req.packet_end = packet_end_i;
  assign step              = stg_valid && out_free;

  amfp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req),
    .advance_i  (step),
    .valid_o    (stg_valid),
    .req_o      (stg_req)
  );

  amfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .req_i       (stg_req),
    .mask_i      (mask_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  amfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign rate_tenths_o   = res_out.rate_tenths;
  assign delta_tenths_o  = res_out.delta_tenths;
  assign point_changed_o = res_out.point_changed;
  assign current_point_o = res_out.current_point;
  assign drive_mode_o    = res_out.drive_mode;

endmodule

### dv/ascii_motion_frame_parser_tb.sv
// Self-checking testbench for ascii_motion_frame_parser: byte stream in, frame results out.
// Depends on amfp_pkg and the ascii_motion_frame_parser RTL; needs no other files.
`timescale 1ns / 1ps

module ascii_motion_frame_parser_tb;
  import amfp_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned BytesPerPhase = 190;

  typedef logic [7:0] byte_q_t[$];

  // Tracks the parser state and queues the frame results that accepted bytes must produce.
  class frame_tracker;
    logic [MaskW-1:0] mask;
    phase_e           phase;
    logic [30:0]      mag;
    bit               neg;
    logic [31:0]      first_val;
    logic [31:0]      second_val;
    logic [3:0]       point;
    result_t          frames_due[$];
    int unsigned      bytes_seen;
    int unsigned      mismatches;

    function new();
      mask       = MaskReset;
      phase      = PH_HUNT;
      mag        = '0;
      neg        = 1'b0;
      first_val  = '0;
      second_val = '0;
      point      = '0;
      bytes_seen = 0;
      mismatches = 0;
    endfunction

    function logic [31:0] field_value();
      return neg ? 32'd0 - {1'b0, mag} : {1'b0, mag};
    endfunction

    function void open_field(phase_e next);
      phase = next;
      mag   = '0;
      neg   = 1'b0;
    endfunction

    function void take_byte(logic [7:0] c, logic last);
      int        idx;
      int        fld;
      sub_e      part;
      logic [35:0] grown;
      result_t   r;
      bytes_seen++;
      case (phase)
        PH_HUNT: if (c == ChDollar) phase = PH_DOLLAR;
        PH_DOLLAR: begin
          if (c == ChM) phase = PH_DOLLAR_M;
          else if (c != ChDollar) phase = PH_HUNT;
        end
        PH_DOLLAR_M: begin
          if (c == ChComma) open_field(PH_F0_START);
          else if (c == ChDollar) phase = PH_DOLLAR;
          else phase = PH_HUNT;
        end
        PH_IDLE: ;
        default: begin
          idx  = int'(phase) - int'(PH_F0_START);
          fld  = idx / 3;
          part = sub_e'(idx % 3);
          if (c >= ChZero && c <= ChNine) begin
            grown = mag * 36'd10 + 36'(c - ChZero);
            mag   = (grown > 36'h7FFF_FFFF) ? 31'h7FFF_FFFF : grown[30:0];
            phase = phase_e'(4'(int'(PH_F0_START) + fld * 3 + int'(SUB_DIG)));
          end else if (part == SUB_START && (c == ChMinus || c == ChPlus)) begin
            neg   = (c == ChMinus);
            phase = phase_e'(4'(int'(PH_F0_START) + fld * 3 + int'(SUB_SIGN)));
          end else if (part != SUB_DIG) begin
            phase = PH_IDLE;
          end else if (fld < 2) begin
            if (c != ChComma) begin
              phase = PH_IDLE;
            end else begin
              if (fld == 0) first_val = field_value();
              else second_val = field_value();
              open_field(phase_e'(4'(int'(PH_F0_START) + (fld + 1) * 3)));
            end
          end else if (c != ChHash) begin
            phase = PH_IDLE;
          end else begin
            phase           = PH_IDLE;
            r.rate_tenths   = first_val;
            r.delta_tenths  = second_val;
            r.point_changed = 1'b0;
            r.drive_mode    = ModeNone;
            if (!neg && mag >= 31'd1 && mag <= 31'(PointMax) && mag[3:0] != point) begin
              point           = mag[3:0];
              r.point_changed = 1'b1;
              r.drive_mode    = mask[point - 4'd1] ? ModeTwo : ModeThree;
            end
            r.current_point = point;
            frames_due.push_back(r);
          end
        end
      endcase
      // packet end always drops back to the hunt, even mid-frame
      if (last) open_field(PH_HUNT);
    endfunction

    function void check_frame(result_t got);
      result_t want;
      if (frames_due.size() == 0) begin
        $error("frame result with none expected");
        mismatches++;
        return;
      end
      want = frames_due.pop_front();
      if (got.rate_tenths !== want.rate_tenths) begin
        $error("rate_tenths: expected %0d, got %0d", want.rate_tenths, got.rate_tenths);
        mismatches++;
      end
      if (got.delta_tenths !== want.delta_tenths) begin
        $error("delta_tenths: expected %0d, got %0d", want.delta_tenths, got.delta_tenths);
        mismatches++;
      end
      if (got.point_changed !== want.point_changed) begin
        $error("point_changed: expected %0d, got %0d", want.point_changed, got.point_changed);
        mismatches++;
      end
      if (got.current_point !== want.current_point) begin
        $error("current_point: expected %0d, got %0d", want.current_point, got.current_point);
        mismatches++;
      end
      if (got.drive_mode !== want.drive_mode) begin
        $error("drive_mode: expected %0d, got %0d", want.drive_mode, got.drive_mode);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte = '0;
  logic               packet_end = 1'b0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic signed [31:0] rate_tenths_o;
  logic signed [31:0] delta_tenths_o;
  logic               point_changed_o;
  logic [3:0]         current_point_o;
  logic [1:0]         drive_mode_o;
  logic               cfg_we = 1'b0;
  logic [MaskW-1:0]   cfg_data = '0;

  frame_tracker tracker = new();

  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned quiet = 0;

  ascii_motion_frame_parser uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte),
    .packet_end_i   (packet_end),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .rate_tenths_o  (rate_tenths_o),
    .delta_tenths_o (delta_tenths_o),
    .point_changed_o(point_changed_o),
    .current_point_o(current_point_o),
    .drive_mode_o   (drive_mode_o),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // result side: check on accept, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      tracker.check_frame(result_t'({rate_tenths_o, delta_tenths_o, point_changed_o,
                                     current_point_o, drive_mode_o}));
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && tracker.bytes_seen >= 300) begin
      // long hold-off so the parser backs up into the input side
      hold_done = 1'b1;
      hold_left = HoldOffCycles;
      out_stall <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(10, 60);
      end
      stall_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_left[1];
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_request(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid   <= 1'b1;
    rx_byte    <= b;
    packet_end <= last;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_byte(b, last);
    burst_left--;
  endtask

  task automatic send_packet(input byte_q_t pkt);
    for (int i = 0; i < pkt.size(); i++) send_request(pkt[i], i == pkt.size() - 1);
  endtask

  // only called between phases, once every frame has come out
  task automatic write_mask(input logic [MaskW-1:0] value);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (tracker.frames_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    tracker.mask = value;
  endtask

  function automatic byte_q_t text_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic void push_value(ref byte_q_t pkt, input bit is_point);
    int unsigned sel;
    int unsigned ndig;
    sel = $urandom_range(0, 9);
    if (is_point && sel < 7) begin
      pkt.push_back(8'(ChZero + $urandom_range(1, 9)));
      return;
    end
    case ($urandom_range(0, 2))
      0: pkt.push_back(ChMinus);
      1: pkt.push_back(ChPlus);
      default: ;
    endcase
    // mostly short numbers, now and then long enough to saturate
    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 5);
    repeat (ndig) pkt.push_back(8'(ChZero + $urandom_range(0, 9)));
  endfunction

  function automatic byte_q_t random_packet();
    byte_q_t pkt;
    int unsigned kind;
    int unsigned pos;
    kind = $urandom_range(0, 19);
    repeat ($urandom_range(0, 2)) pkt.push_back(8'($urandom));
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
      return pkt;
    end
    if (kind == 1) pkt.push_back(ChDollar);
    pkt.push_back(ChDollar);
    pkt.push_back(ChM);
    pkt.push_back(ChComma);
    push_value(pkt, 1'b0);
    pkt.push_back(ChComma);
    push_value(pkt, 1'b0);
    pkt.push_back(ChComma);
    push_value(pkt, 1'b1);
    pkt.push_back(ChHash);
    pos = $urandom_range(0, pkt.size() - 1);
    case (kind)
      2: pkt[pos] = 8'($urandom);
      3: pkt = pkt[0:$urandom_range(0, pkt.size() - 2)];
      4: pkt.delete(pos);
      5: pkt = {pkt, pkt};
      default: ;
    endcase
    repeat ($urandom_range(0, 2)) pkt.push_back(8'($urandom));
    return pkt;
  endfunction

  initial begin
    byte_q_t q;
    logic [MaskW-1:0] m;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_packet(text_bytes("$$M,9,-1,3#"));
    // same point again, then junk after the closing hash up to the packet end
    q = text_bytes("$M,0,+0,3#");
    q.push_back(8'h00);
    q.push_back(8'hFF);
    send_packet(q);
    send_packet(text_bytes("$M,"));
    send_packet(text_bytes("$M,5"));
    send_packet(text_bytes("$M,x"));
    send_packet(text_bytes("$M,-4,2,-9#"));
    send_packet(text_bytes("$M,1,2,12#"));

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        case (ph)
          1: m = '0;
          2: m = '1;
          default: m = MaskW'($urandom);
        endcase
        write_mask(m);
      end
      while (tracker.bytes_seen < (ph + 1) * BytesPerPhase) send_packet(random_packet());
    end

    in_valid <= 1'b0;
    while (tracker.frames_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
